/* src/pfm_pkg.sv */
// Package for the LRU page frame manager: sizes, operation and status codes,
// channel payload structs and the control structs passed between submodules.
// No dependencies.
package pfm_pkg;

   localparam int FRAMES       = 4;
   localparam int FRAME_W      = $clog2(FRAMES);
   localparam int DISK_PAGES   = 16;
   localparam int ID_W         = $clog2(DISK_PAGES);
   localparam int CNT_W        = $clog2(DISK_PAGES) + 1;
   localparam int AGE_BITS_DEF = 8;

   localparam logic [1:0] KIND_ACCESS = 2'd0;
   localparam logic [1:0] KIND_ALLOC  = 2'd1;
   localparam logic [1:0] KIND_FREE   = 2'd2;
   localparam logic [1:0] KIND_RSVD   = 2'd3;

   localparam logic [2:0] STATUS_HIT     = 3'd0;
   localparam logic [2:0] STATUS_MISS    = 3'd1;
   localparam logic [2:0] STATUS_ALLOC   = 3'd2;
   localparam logic [2:0] STATUS_FREED   = 3'd3;
   localparam logic [2:0] STATUS_NO_ID   = 3'd4;

   typedef struct packed {
      logic [1:0]      kind;
      logic [ID_W-1:0] page_id;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [FRAME_W-1:0] frame_index;
      logic               evicted_valid;
      logic [ID_W-1:0]    evicted_page;
      logic [ID_W-1:0]    new_page_id;
   } rsp_type;

   // one operation presented to the state-holding units
   typedef struct packed {
      logic            fire;
      logic [1:0]      kind;
      logic [ID_W-1:0] page_id;
   } op_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame_index;
      logic               evicted_valid;
      logic [ID_W-1:0]    evicted_page;
   } frame_res_type;

   typedef struct packed {
      logic            ok;
      logic [ID_W-1:0] new_page_id;
   } id_res_type;

endpackage

/* src/pfm_frame_table.sv */
// Frame table: valid/page/age per frame, hit lookup, empty-frame and
// oldest-frame selection, and the per-operation update. Uses pfm_pkg.
module pfm_frame_table #(
   parameter int AGE_BITS = pfm_pkg::AGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pfm_pkg::op_type       op,
   output pfm_pkg::frame_res_type res
);

   localparam int FRAMES  = pfm_pkg::FRAMES;
   localparam int FRAME_W = pfm_pkg::FRAME_W;
   localparam int ID_W    = pfm_pkg::ID_W;
   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   logic                valid_ff [FRAMES];
   logic                valid_in [FRAMES];
   logic [ID_W-1:0]     page_ff  [FRAMES];
   logic [ID_W-1:0]     page_in  [FRAMES];
   logic [AGE_BITS-1:0] age_ff   [FRAMES];
   logic [AGE_BITS-1:0] age_in   [FRAMES];

   logic                hit;
   logic [FRAME_W-1:0]  hit_idx;
   logic                any_empty;
   logic [FRAME_W-1:0]  empty_idx;
   logic [FRAME_W-1:0]  victim_idx;
   logic [AGE_BITS-1:0] victim_age;
   logic [ID_W-1:0]     victim_page;
   logic [FRAME_W-1:0]  target;
   logic                do_access;
   logic                do_free;
   logic                dup_page;

   assign do_access = op.fire && (op.kind == pfm_pkg::KIND_ACCESS);
   assign do_free   = op.fire && (op.kind == pfm_pkg::KIND_FREE);

   // lookup and selection; lowest frame wins every tie
   always_comb begin
      hit         = 1'b0;
      hit_idx     = '0;
      any_empty   = 1'b0;
      empty_idx   = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == op.page_id)) begin
            hit     = 1'b1;
            hit_idx = FRAME_W'(i);
         end
         if (!valid_ff[i]) begin
            any_empty = 1'b1;
            empty_idx = FRAME_W'(i);
         end
      end
      victim_idx  = '0;
      victim_age  = age_ff[0];
      victim_page = page_ff[0];
      for (int i = 1; i < FRAMES; i++) begin
         if (age_ff[i] > victim_age) begin
            victim_idx  = FRAME_W'(i);
            victim_age  = age_ff[i];
            victim_page = page_ff[i];
         end
      end
      if (hit)
         target = hit_idx;
      else if (any_empty)
         target = empty_idx;
      else
         target = victim_idx;
   end

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         valid_in[i] = valid_ff[i];
         page_in[i]  = page_ff[i];
         age_in[i]   = age_ff[i];
         if (do_access) begin
            if (target == FRAME_W'(i)) begin
               valid_in[i] = 1'b1;
               page_in[i]  = op.page_id;
               age_in[i]   = '0;
            end
            if (valid_in[i] && (age_in[i] != AGE_MAX))
               age_in[i] = age_in[i] + 1'b1;
         end else if (do_free && hit && (hit_idx == FRAME_W'(i))) begin
            valid_in[i] = 1'b0;
            page_in[i]  = '0;
            age_in[i]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
            page_ff[i]  <= '0;
            age_ff[i]   <= '0;
         end
      end else begin
         for (int i = 0; i < FRAMES; i++) begin
            valid_ff[i] <= valid_in[i];
            page_ff[i]  <= page_in[i];
            age_ff[i]   <= age_in[i];
         end
      end
   end

   always_comb begin
      res.hit           = hit;
      res.evicted_valid = do_access && !hit && !any_empty;
      res.evicted_page  = res.evicted_valid ? victim_page : '0;
      case (op.kind)
         pfm_pkg::KIND_ACCESS: res.frame_index = target;
         pfm_pkg::KIND_FREE:   res.frame_index = hit_idx;
         default:              res.frame_index = '0;
      endcase
   end

   // a page never sits in two valid frames
   always_comb begin
      dup_page = 1'b0;
      for (int i = 0; i < FRAMES; i++)
         for (int j = i + 1; j < FRAMES; j++)
            if (valid_ff[i] && valid_ff[j] && (page_ff[i] == page_ff[j]))
               dup_page = 1'b1;
   end

   a_no_dup_page: assert property (@(posedge clock) disable iff (reset) !dup_page)
      else $error("page held by two frames");

   a_empty_frame_young: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> (age_ff[0] == '0))
      else $error("empty frame has nonzero age");

   a_access_fills: assert property (@(posedge clock) disable iff (reset)
      do_access && !any_empty |=> valid_ff[0])
      else $error("full table lost frame 0 on access");

endmodule

/* src/pfm_id_alloc.sv */
// Page id allocator: freed-id map with lowest-first reuse and a fresh-id
// counter. Uses pfm_pkg.
module pfm_id_alloc (
   input  logic               clock,
   input  logic               reset,
   input  pfm_pkg::op_type    op,
   output pfm_pkg::id_res_type res
);

   localparam int DISK_PAGES = pfm_pkg::DISK_PAGES;
   localparam int ID_W       = pfm_pkg::ID_W;
   localparam int CNT_W      = pfm_pkg::CNT_W;

   logic [DISK_PAGES-1:0] freed_ff;
   logic [DISK_PAGES-1:0] freed_in;
   logic [CNT_W-1:0]      fresh_ff;
   logic [CNT_W-1:0]      fresh_in;
   logic                  any_freed;
   logic [ID_W-1:0]       freed_idx;
   logic [CNT_W-1:0]      fresh_next;
   logic                  fresh_ok;

   always_comb begin
      any_freed = 1'b0;
      freed_idx = '0;
      for (int i = DISK_PAGES - 1; i >= 0; i--) begin
         if (freed_ff[i]) begin
            any_freed = 1'b1;
            freed_idx = ID_W'(i);
         end
      end
   end

   assign fresh_next = fresh_ff + 1'b1;
   assign fresh_ok   = fresh_next < CNT_W'(DISK_PAGES);

   always_comb begin
      freed_in = freed_ff;
      fresh_in = fresh_ff;
      if (op.fire) begin
         case (op.kind)
            pfm_pkg::KIND_ALLOC: begin
               if (any_freed)
                  freed_in[freed_idx] = 1'b0;
               else if (fresh_ok)
                  fresh_in = fresh_next;
            end
            pfm_pkg::KIND_FREE: begin
               if (CNT_W'(op.page_id) < CNT_W'(DISK_PAGES))
                  freed_in[op.page_id] = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freed_ff <= '0;
         fresh_ff <= '0;
      end else begin
         freed_ff <= freed_in;
         fresh_ff <= fresh_in;
      end
   end

   always_comb begin
      res.ok = any_freed || fresh_ok;
      if (any_freed)
         res.new_page_id = freed_idx;
      else if (fresh_ok)
         res.new_page_id = fresh_next[ID_W-1:0];
      else
         res.new_page_id = '0;
   end

   a_fresh_in_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff < CNT_W'(DISK_PAGES))
      else $error("fresh id counter out of range");

endmodule

/* src/lru_page_frame_manager.sv */
// LRU page frame manager, top level. A request passes the input register, then
// the result register, before its response is valid.
// Throughput: one request per cycle unless the response stalls; the frame
// lookup, oldest-frame select and id priority encode all finish between the
// two registers. A stalled response holds the input register, which stalls
// requests until the response drains.
// Reset (synchronous, active high) empties all frames, clears ages, the freed
// map and the fresh id counter, and drops both pipeline registers.
// Uses pfm_pkg, pfm_frame_table, pfm_id_alloc.
module lru_page_frame_manager #(
   parameter int AGE_BITS = pfm_pkg::AGE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfm_pkg::rsp_type rsp_payload
);

   // input register
   logic             in_valid_ff;
   logic             in_valid_in;
   pfm_pkg::req_type in_req_ff;
   pfm_pkg::req_type in_req_in;

   // result register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   pfm_pkg::rsp_type rsp_ff;
   pfm_pkg::rsp_type rsp_in;

   logic                  advance;
   logic                  fire;
   logic                  req_take;
   pfm_pkg::op_type       op;
   pfm_pkg::frame_res_type frame_res;
   pfm_pkg::id_res_type    id_res;

   // The held request moves on when it makes no response (reserved kind) or
   // the result register is free or being drained this cycle.
   assign advance   = (in_req_ff.kind == pfm_pkg::KIND_RSVD) || !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign op.fire    = fire;
   assign op.kind    = in_req_ff.kind;
   assign op.page_id = in_req_ff.page_id;

   pfm_frame_table #(
      .AGE_BITS (AGE_BITS)
   ) u_frame_table (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (frame_res)
   );

   pfm_id_alloc u_id_alloc (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (id_res)
   );

   // response assembly per operation kind
   always_comb begin
      rsp_in               = '0;
      rsp_in.frame_index   = frame_res.frame_index;
      rsp_in.evicted_valid = frame_res.evicted_valid;
      rsp_in.evicted_page  = frame_res.evicted_page;
      case (in_req_ff.kind)
         pfm_pkg::KIND_ACCESS: begin
            rsp_in.status = frame_res.hit ? pfm_pkg::STATUS_HIT : pfm_pkg::STATUS_MISS;
         end
         pfm_pkg::KIND_ALLOC: begin
            rsp_in.status      = id_res.ok ? pfm_pkg::STATUS_ALLOC : pfm_pkg::STATUS_NO_ID;
            rsp_in.new_page_id = id_res.new_page_id;
         end
         pfm_pkg::KIND_FREE: begin
            rsp_in.status = pfm_pkg::STATUS_FREED;
         end
         default: rsp_in.status = pfm_pkg::STATUS_HIT;
      endcase
   end

   always_comb begin
      in_req_in   = in_req_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_req_in   = req_payload;
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire && (in_req_ff.kind != pfm_pkg::KIND_RSVD))
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_req_ff <= in_req_in;
      if (fire && (in_req_ff.kind != pfm_pkg::KIND_RSVD))
         rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire && (in_req_ff.kind != pfm_pkg::KIND_RSVD) |=> rsp_valid_ff)
      else $error("processed request produced no response");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.evicted_valid |-> (rsp_ff.status == pfm_pkg::STATUS_MISS))
      else $error("eviction reported without a miss");

   a_new_id_only_on_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != pfm_pkg::STATUS_ALLOC) |-> (rsp_ff.new_page_id == '0))
      else $error("page id reported outside an allocation");

endmodule
